@@ sv/tlbsa_pkg.sv @@
package tlbsa_pkg;

    localparam int WORD_BITS    = 64;
    localparam int LOG_WORD     = 6;
    localparam int DEF_CAPACITY = 16384;
    localparam int CFG_W        = 15;
    localparam int IDX_W        = 14;
    localparam int RESET_COUNT  = 16384;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 24;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    // register select is paddr[2]
    localparam logic REG_SLOT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_REINIT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_REINIT,
        S_SUM_RD,
        S_SUM_LD,
        S_SUM_SCAN,
        S_LEAF_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_QRY_RD,
        S_QRY_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic sweep_step;
        logic sum_ld;
        logic h_inc;
        logic set_full;
        logic repair;
        logic grant;
        logic free_rd;
        logic free_wr;
        logic qry_rd;
        logic qry_chk;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic in_oor;
        logic sum_full;
        logic li_oob;
        logic leaf_full;
        logic h_last;
        logic sweep_last;
        logic out_busy;
    } stat_t;

    // halving search: six steps, all ones gives the top bit
    function automatic logic [LOG_WORD-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] mask;
        logic [LOG_WORD-1:0]  r;
        v = w;
        r = '0;
        for (int k = LOG_WORD - 1; k >= 0; k--)
        begin
            mask = (64'd1 << (1 << k)) - 64'd1;
            if ((v & mask) == mask)
            begin
                r[k] = 1'b1;
                v    = v >> (1 << k);
            end
        end
        return r;
    endfunction

endpackage

@@ sv/tlbsa_ram.sv @@
module tlbsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tlbsa_ctrl.sv @@
module tlbsa_ctrl
    import tlbsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (stat.in_op)
                        OP_ALLOC:  state_next = S_SUM_RD;
                        OP_FREE:   state_next = stat.in_oor ? S_DONE : S_FREE_RD;
                        OP_QUERY:  state_next = stat.in_oor ? S_DONE : S_QRY_RD;
                        OP_REINIT: state_next = S_REINIT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REINIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_LD;
            end
            S_SUM_LD:
            begin
                cmd.sum_ld = 1'b1;
                state_next = S_SUM_SCAN;
            end
            S_SUM_SCAN:
            begin
                if (stat.sum_full)
                begin
                    if (stat.h_last)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.h_inc  = 1'b1;
                        state_next = S_SUM_RD;
                    end
                end
                else if (stat.li_oob)
                begin
                    // leaf word does not exist: mark it full in place
                    cmd.repair = 1'b1;
                end
                else
                begin
                    state_next = S_LEAF_CHK;
                end
            end
            S_LEAF_CHK:
            begin
                if (stat.leaf_full)
                begin
                    // stale summary bit
                    cmd.repair = 1'b1;
                    state_next = S_SUM_SCAN;
                end
                else
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_QRY_RD:
            begin
                cmd.qry_rd = 1'b1;
                state_next = S_QRY_CHK;
            end
            S_QRY_CHK:
            begin
                cmd.qry_chk = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/tlbsa_dpath.sv @@
module tlbsa_dpath
    import tlbsa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [1:0]            in_user,
    input  logic [CFG_W-1:0]      slot_count,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output stat_t                 stat
);

    localparam int NUM_LEAF   = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int NUM_SUM    = (NUM_LEAF + WORD_BITS - 1) / WORD_BITS;
    // at least two summary words; extra ones only hold bits of missing leaf words
    localparam int NUM_SUM_P  = (NUM_SUM < 2) ? 2 : NUM_SUM;
    localparam int SI_W       = $clog2(NUM_SUM_P);
    localparam int LI_W       = SI_W + LOG_WORD;
    localparam int SLOT_W     = LI_W + LOG_WORD;
    localparam int LEAF_AW    = (NUM_LEAF > 1) ? $clog2(NUM_LEAF) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ACT_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BASE_W     = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int INIT_COUNT = (RESET_COUNT < CAPACITY) ? RESET_COUNT : CAPACITY;
    localparam int SWEEP_END  = NUM_SUM_P * WORD_BITS - 1;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    logic [SI_W-1:0]       h_reg;
    logic [LI_W-1:0]       sweep_reg;
    logic [CNT_W-1:0]      n_reg;
    logic                  out_valid_reg;
    logic [WORD_BITS-1:0]  acc_reg;
    logic [WORD_BITS-1:0]  sum_word_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SLOT_W-1:0]     res_index_reg;
    logic                  res_granted_reg;
    logic                  res_bit_reg;
    status_t               res_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [IDX_W-1:0]      in_idx;
    op_t                   in_op;
    logic [ACT_W-1:0]      cnt_e;
    logic [ACT_W-1:0]      cap_e;
    logic [ACT_W-1:0]      act_e;
    logic                  oor;
    logic [SLOT_W-1:0]     idx_s;
    logic [LI_W-1:0]       idx_leaf;
    logic [SI_W-1:0]       idx_sum;
    logic [LOG_WORD-1:0]   c_cur;
    logic [LI_W-1:0]       li_cur;
    logic [WORD_BITS-1:0]  cbit;
    logic                  li_oob;
    logic [LOG_WORD-1:0]   b_cur;
    logic [WORD_BITS-1:0]  leaf_set;
    logic [BASE_W-1:0]     base;
    logic [BASE_W-1:0]     n_e;
    logic [BASE_W-1:0]     diff;
    logic [WORD_BITS-1:0]  fill_word;
    logic                  sweep_oob;
    logic                  sweep_full;
    logic [WORD_BITS-1:0]  acc_next;

    logic                  leaf_we;
    logic [LEAF_AW-1:0]    leaf_waddr;
    logic [WORD_BITS-1:0]  leaf_wdata;
    logic [LEAF_AW-1:0]    leaf_raddr;
    logic [WORD_BITS-1:0]  leaf_rdata;
    logic                  sum_we;
    logic [SI_W-1:0]       sum_waddr;
    logic [WORD_BITS-1:0]  sum_wdata;
    logic [SI_W-1:0]       sum_raddr;
    logic [WORD_BITS-1:0]  sum_rdata;

    assign in_idx = in_data[IDX_W-1:0];
    assign in_op  = op_t'(in_user);

    // active count is the register capped at capacity
    assign cnt_e = ACT_W'(slot_count);
    assign cap_e = ACT_W'(CAPACITY);
    assign act_e = (cnt_e > cap_e) ? cap_e : cnt_e;
    assign oor   = ACT_W'(in_idx) >= act_e;

    assign idx_s    = SLOT_W'(idx_reg);
    assign idx_leaf = idx_s[SLOT_W-1:LOG_WORD];
    assign idx_sum  = idx_s[SLOT_W-1:2*LOG_WORD];

    assign c_cur  = lowest_zero(sum_word_reg);
    assign li_cur = {h_reg, c_cur};
    assign cbit   = 64'd1 << c_cur;
    assign li_oob = {1'b0, li_cur} >= (LI_W + 1)'(NUM_LEAF);

    assign b_cur    = lowest_zero(leaf_rdata);
    assign leaf_set = leaf_rdata | (64'd1 << b_cur);

    // reinit word for leaf sweep_reg
    assign base      = BASE_W'({sweep_reg, {LOG_WORD{1'b0}}});
    assign n_e       = BASE_W'(n_reg);
    assign diff      = n_e - base;
    assign sweep_oob = {1'b0, sweep_reg} >= (LI_W + 1)'(NUM_LEAF);

    always_comb
    begin
        if (base >= n_e)
        begin
            fill_word = ONES;
        end
        else if (diff >= BASE_W'(WORD_BITS))
        begin
            fill_word = '0;
        end
        else
        begin
            fill_word = ONES << diff[LOG_WORD-1:0];
        end
        sweep_full = sweep_oob || (fill_word == ONES);
        acc_next   = acc_reg;
        acc_next[sweep_reg[LOG_WORD-1:0]] = sweep_full;
    end

    always_comb
    begin
        leaf_we    = 1'b0;
        leaf_waddr = LEAF_AW'(sweep_reg);
        leaf_wdata = fill_word;
        leaf_raddr = LEAF_AW'(li_cur);
        sum_we     = 1'b0;
        sum_waddr  = h_reg;
        sum_wdata  = sum_word_reg | cbit;
        sum_raddr  = h_reg;
        if (cmd.sweep_step)
        begin
            leaf_we = !sweep_oob;
            if (sweep_reg[LOG_WORD-1:0] == LOG_WORD'(WORD_BITS - 1))
            begin
                sum_we    = 1'b1;
                sum_waddr = sweep_reg[LI_W-1:LOG_WORD];
                sum_wdata = acc_next;
            end
        end
        if (cmd.repair)
        begin
            sum_we = 1'b1;
        end
        if (cmd.grant)
        begin
            leaf_we    = 1'b1;
            leaf_waddr = LEAF_AW'(li_cur);
            leaf_wdata = leaf_set;
            sum_we     = (leaf_set == ONES);
        end
        if (cmd.free_rd || cmd.qry_rd)
        begin
            leaf_raddr = LEAF_AW'(idx_leaf);
            sum_raddr  = idx_sum;
        end
        if (cmd.free_wr)
        begin
            leaf_we    = 1'b1;
            leaf_waddr = LEAF_AW'(idx_leaf);
            leaf_wdata = leaf_rdata & ~(64'd1 << idx_s[LOG_WORD-1:0]);
            sum_we     = 1'b1;
            sum_waddr  = idx_sum;
            sum_wdata  = sum_rdata & ~(64'd1 << idx_s[2*LOG_WORD-1:LOG_WORD]);
        end
    end

    tlbsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_LEAF)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    tlbsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_SUM_P)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= '0;
            sweep_reg     <= '0;
            n_reg         <= CNT_W'(INIT_COUNT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                h_reg     <= '0;
                sweep_reg <= '0;
                if (in_op == OP_REINIT)
                begin
                    n_reg <= CNT_W'(act_e);
                end
            end
            if (cmd.h_inc)
            begin
                h_reg <= h_reg + 1'b1;
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg         <= in_idx;
            res_index_reg   <= '0;
            res_granted_reg <= 1'b0;
            res_bit_reg     <= 1'b0;
            if ((in_op == OP_FREE || in_op == OP_QUERY) && oor)
            begin
                res_status_reg <= STS_RANGE;
            end
            else
            begin
                res_status_reg <= STS_OK;
            end
        end
        if (cmd.sweep_step)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.sum_ld)
        begin
            sum_word_reg <= sum_rdata;
        end
        if (cmd.repair)
        begin
            sum_word_reg <= sum_word_reg | cbit;
        end
        if (cmd.set_full)
        begin
            res_status_reg <= STS_FULL;
        end
        if (cmd.grant)
        begin
            res_index_reg   <= {li_cur, b_cur};
            res_granted_reg <= 1'b1;
        end
        if (cmd.qry_chk)
        begin
            res_bit_reg <= leaf_rdata[idx_s[LOG_WORD-1:0]];
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {6'd0, res_status_reg, res_bit_reg, res_granted_reg,
                             IDX_W'(res_index_reg)};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.in_op      = in_op;
    assign stat.in_oor     = oor;
    assign stat.sum_full   = (sum_word_reg == ONES);
    assign stat.li_oob     = li_oob;
    assign stat.leaf_full  = (leaf_rdata == ONES);
    assign stat.h_last     = (h_reg == SI_W'(NUM_SUM - 1));
    assign stat.sweep_last = (sweep_reg == LI_W'(SWEEP_END));
    assign stat.out_busy   = out_valid_reg && !out_ready;

endmodule

@@ sv/two_level_bitmap_slot_allocator_unit.sv @@
// allocate: reads, loads and scans a summary word, skips each full summary word and repairs
//   each stale summary bit, then reads and checks the leaf word; one summary word at a time
// free and query: read, then write or check the leaf word; out of range goes straight to done
// reinitialize: sweeps the leaf words of every summary word, one leaf word written per cycle
// result is loaded into the output register from the done state once that register is free
// reset (async, active low) runs the same clearing pass, ready low
module two_level_bitmap_slot_allocator_unit
    import tlbsa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // slot_index[13:0], zero pad
    input  logic [1:0]            s_axis_tuser,   // operation[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // granted_index[13:0], granted, bit_value,
                                                  // status[1:0], zero pad
);

    logic [CFG_W-1:0] slot_count_reg;
    cmd_t             cmd;
    stat_t            stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= CFG_W'(RESET_COUNT);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLOT_COUNT))
        begin
            slot_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLOT_COUNT) ? APB_DW'(slot_count_reg) : '0;

    tlbsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    tlbsa_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .slot_count (slot_count_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .stat       (stat)
    );

    // one word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in work");

    // a grant always reports ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[17:16] == STS_OK)
        else $error("grant with nonzero status");

    // allocate and query results never mix
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[14] && m_axis_tdata[15]))
        else $error("grant and bit_value both set");

endmodule

@@ dv/tb_two_level_bitmap_slot_allocator_unit.sv @@
`timescale 1ns / 1ps

module tb_two_level_bitmap_slot_allocator_unit;
    import tlbsa_pkg::*;

    localparam int SLOTS      = DEF_CAPACITY;
    localparam int LEAF_WORDS = SLOTS / WORD_BITS;
    localparam int SUM_WORDS  = LEAF_WORDS / WORD_BITS;
    localparam logic [APB_AW-1:0] SLOT_COUNT_ADDR = {REG_SLOT_COUNT, 2'b00};

    typedef struct {
        logic [IDX_W-1:0] granted_index;
        logic             granted;
        logic             bit_value;
        status_t          status;
    } reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // slot_index[13:0], zero pad
    logic [1:0]            s_axis_tuser;   // operation[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // granted_index[13:0], granted, bit_value,
                                           // status[1:0], zero pad

    // local copy of the allocator state
    logic [WORD_BITS-1:0] leaf_map [LEAF_WORDS];
    logic [WORD_BITS-1:0] full_map [SUM_WORDS];
    logic [CFG_W-1:0]     count_reg;

    reply_t           pending_replies [$];
    logic [IDX_W-1:0] held_slots [$];
    int               mismatches   = 0;
    int               in_idle_pct  = 24;
    int               out_idle_pct = 24;
    int               stall_left   = 0;

    two_level_bitmap_slot_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic int usable_slots();
        return (count_reg > SLOTS) ? SLOTS : int'(count_reg);
    endfunction

    function automatic int first_clear(input logic [WORD_BITS-1:0] w);
        for (int i = 0; i < WORD_BITS - 1; i++)
        begin
            if (!w[i])
                return i;
        end
        return WORD_BITS - 1;
    endfunction

    // clear the store, reserve slots at and above the count
    function automatic void rebuild_map();
        int n;
        int base;
        n = usable_slots();
        for (int i = 0; i < LEAF_WORDS; i++)
        begin
            base = i * WORD_BITS;
            if (base >= n)
                leaf_map[i] = '1;
            else if (n - base >= WORD_BITS)
                leaf_map[i] = '0;
            else
                leaf_map[i] = ~((64'd1 << (n - base)) - 64'd1);
        end
        for (int h = 0; h < SUM_WORDS; h++)
            full_map[h] = '0;
        for (int i = 0; i < LEAF_WORDS; i++)
        begin
            if (leaf_map[i] == '1)
                full_map[i / WORD_BITS][i % WORD_BITS] = 1'b1;
        end
    endfunction

    function automatic reply_t compute_reply(input op_t op, input logic [IDX_W-1:0] idx);
        reply_t r;
        int     c;
        int     li;
        int     b;
        logic   done;
        r.granted_index = '0;
        r.granted       = 1'b0;
        r.bit_value     = 1'b0;
        r.status        = STS_OK;
        done            = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                r.status = STS_FULL;
                for (int h = 0; h < SUM_WORDS && !done; h++)
                begin
                    while (!done && full_map[h] != '1)
                    begin
                        c  = first_clear(full_map[h]);
                        li = h * WORD_BITS + c;
                        if (leaf_map[li] == '1)
                        begin
                            // summary bit out of date, fix it and look again
                            full_map[h][c] = 1'b1;
                        end
                        else
                        begin
                            b = first_clear(leaf_map[li]);
                            leaf_map[li][b] = 1'b1;
                            if (leaf_map[li] == '1)
                                full_map[h][c] = 1'b1;
                            r.granted_index = IDX_W'(li * WORD_BITS + b);
                            r.granted       = 1'b1;
                            r.status        = STS_OK;
                            done            = 1'b1;
                        end
                    end
                end
            end
            OP_FREE, OP_QUERY:
            begin
                if (int'(idx) >= usable_slots())
                    r.status = STS_RANGE;
                else
                begin
                    li = int'(idx) / WORD_BITS;
                    if (op == OP_FREE)
                    begin
                        leaf_map[li][idx[LOG_WORD-1:0]]          = 1'b0;
                        full_map[li / WORD_BITS][li % WORD_BITS] = 1'b0;
                    end
                    else
                        r.bit_value = leaf_map[li][idx[LOG_WORD-1:0]];
                end
            end
            default:
                rebuild_map();
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx);
        reply_t reply;
        while ($urandom_range(99) < in_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - IDX_W){1'b0}}, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        reply = compute_reply(op, idx);
        pending_replies.push_back(reply);
        if (op == OP_REINIT)
            held_slots.delete();
        if (reply.granted)
            held_slots.push_back(reply.granted_index);
    endtask

    task automatic send_random(input int alloc_w, input int free_w, input int query_w,
                               input int reinit_w);
        int               pick;
        int               n;
        int               k;
        op_t              op;
        logic [IDX_W-1:0] idx;
        n    = usable_slots();
        pick = $urandom_range(alloc_w + free_w + query_w + reinit_w - 1);
        if (pick < alloc_w)
            op = OP_ALLOC;
        else if (pick < alloc_w + free_w)
            op = OP_FREE;
        else if (pick < alloc_w + free_w + query_w)
            op = OP_QUERY;
        else
            op = OP_REINIT;
        pick = $urandom_range(99);
        if (pick < 45 && held_slots.size() != 0)
        begin
            k   = $urandom_range(held_slots.size() - 1);
            idx = held_slots[k];
            if (op == OP_FREE)
                held_slots.delete(k);
        end
        else if (pick < 80 && n > 0)
            idx = IDX_W'($urandom_range(n - 1));
        else
            idx = IDX_W'($urandom);
        send_word(op, idx);
    endtask

    // let every outstanding reply come back with the input quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_slot_count(input logic [CFG_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLOT_COUNT_ADDR;
        pwdata  <= {17'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        count_reg = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CFG_W-1:0] !== value)
            report_mismatch("slot_count readback", int'(prdata[CFG_W-1:0]), int'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(OP_QUERY, 0);
        send_word(OP_ALLOC, IDX_W'($urandom));
        send_word(OP_ALLOC, '1);
        send_word(OP_QUERY, 1);
        send_word(OP_FREE, 1);
        send_word(OP_QUERY, 1);
        send_word(OP_ALLOC, 0);
        send_word(OP_QUERY, IDX_W'(SLOTS - 1));
        send_word(OP_FREE, IDX_W'(SLOTS - 1));
        send_word(OP_FREE, 0);
        send_word(OP_ALLOC, 0);
        send_word(OP_REINIT, '1);
        send_word(OP_QUERY, 0);
        // count drops, store keeps its free slots until reinit
        set_slot_count(0);
        send_word(OP_QUERY, 0);
        send_word(OP_FREE, IDX_W'(SLOTS - 1));
        send_word(OP_ALLOC, 0);
        send_word(OP_REINIT, 0);
        send_word(OP_ALLOC, 0);
        send_word(OP_QUERY, 0);
        // count back up over a fully reserved store
        set_slot_count(CFG_W'(SLOTS));
        send_word(OP_QUERY, 5);
        send_word(OP_FREE, 5);
        send_word(OP_ALLOC, 0);
        send_word(OP_ALLOC, 0);
        send_word(OP_REINIT, 0);
    endtask

    task automatic test_count_extremes();
        int counts [14] = '{0, 1, 2, 63, 64, 65, 127, 4095, 4096, 4097, 16383, 16384,
                            16385, 32767};
        int n;
        foreach (counts[i])
        begin
            set_slot_count(CFG_W'(counts[i]));
            n = (counts[i] > SLOTS) ? SLOTS : counts[i];
            send_word(OP_REINIT, IDX_W'($urandom));
            repeat (3) send_word(OP_ALLOC, IDX_W'($urandom));
            send_word(OP_QUERY, IDX_W'((n > 0) ? n - 1 : 0));
            send_word(OP_QUERY, IDX_W'(n));
            send_word(OP_FREE, IDX_W'((n > 0) ? n - 1 : 0));
            send_word(OP_ALLOC, IDX_W'($urandom));
        end
    endtask

    task automatic test_fill_and_release();
        repeat (2)
        begin
            set_slot_count(CFG_W'($urandom_range(1, 300)));
            send_word(OP_REINIT, IDX_W'($urandom));
            repeat (150) send_random(65, 20, 15, 0);
            repeat (100) send_random(20, 55, 25, 0);
        end
    endtask

    // everything reserved, then holes punched all over so the scan has to skip
    task automatic test_sparse_top();
        set_slot_count(0);
        send_word(OP_REINIT, IDX_W'($urandom));
        set_slot_count(CFG_W'(SLOTS));
        repeat (40) send_word(OP_FREE, IDX_W'($urandom));
        repeat (200) send_random(45, 25, 30, 0);
    endtask

    task automatic test_output_stall();
        wait_idle();
        in_idle_pct = 0;
        stall_left  = 400;
        repeat (30) send_random(50, 25, 25, 0);
        wait_idle();
        in_idle_pct = 24;
    endtask

    task automatic test_random_mix();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        repeat (200) send_random(40, 30, 28, 2);
        in_idle_pct  = 24;
        out_idle_pct = 24;
        repeat (4)
        begin
            case ($urandom_range(3))
                0: set_slot_count(CFG_W'($urandom_range(1, 600)));
                1: set_slot_count(CFG_W'($urandom_range(0, 32767)));
                2: set_slot_count(CFG_W'(SLOTS));
                default: set_slot_count(CFG_W'($urandom_range(4000, 4200)));
            endcase
            repeat (150) send_random(40, 30, 28, 2);
        end
    endtask

    initial
    begin : reply_checker
        reply_t                want;
        logic [OUT_DATA_W-1:0] word;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                word = m_axis_tdata;
                if (pending_replies.size() == 0)
                    report_mismatch("unexpected word", int'(word), 0);
                else
                begin
                    want = pending_replies.pop_front();
                    if (word[13:0] !== want.granted_index)
                        report_mismatch("granted_index", int'(word[13:0]),
                                        int'(want.granted_index));
                    if (word[14] !== want.granted)
                        report_mismatch("granted", int'(word[14]), int'(want.granted));
                    if (word[15] !== want.bit_value)
                        report_mismatch("bit_value", int'(word[15]), int'(want.bit_value));
                    if (word[17:16] !== want.status)
                        report_mismatch("status", int'(word[17:16]), int'(want.status));
                end
            end
        end
    end

    // receiver: random idling, and a long hold-off while stall_left runs down
    initial
    begin : ready_driver
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        count_reg = CFG_W'(RESET_COUNT);
        rebuild_map();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_count_extremes();
        test_fill_and_release();
        test_sparse_top();
        test_output_stall();
        test_random_mix();
        wait_idle();
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
